// ===== rtl/tbpa_pkg.sv =====
package tbpa_pkg;

	localparam int TREE_LEVELS = 10;
	localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
	localparam int PAGE_TOTAL  = 1 << (TREE_LEVELS - 1);
	localparam int NODE_W      = TREE_LEVELS;
	localparam int PAGE_W      = TREE_LEVELS - 1;
	localparam int COUNT_W     = PAGE_W + 1;
	localparam int LVL_W       = $clog2(TREE_LEVELS + 1);
	localparam int K_W         = $clog2(TREE_LEVELS);

	typedef enum logic [1:0] {
		NS_EMPTY = 2'd0,
		NS_PART  = 2'd1,
		NS_FULL  = 2'd2,
		NS_ALLOC = 2'd3
	} node_state_t;

	typedef enum logic [1:0] {
		RS_OK      = 2'd0,
		RS_NOSPACE = 2'd1,
		RS_BADCNT  = 2'd2,
		RS_NOTHING = 2'd3
	} result_status_t;

	typedef struct packed {
		logic           load;
		logic           rd_node;
		logic           rd_sib;
		logic           descend;
		logic           back;
		logic           climb;
		logic           wr_alloc;
		logic           wr_empty;
		logic           up;
		logic           clr;
		logic           finish;
		result_status_t fin_status;
	} dp_cmd_t;

	typedef struct packed {
		node_state_t rd_state;
		logic        at_target;
		logic        is_root;
		logic        is_odd;
		logic        parent_root;
		logic        bad_count;
		logic        miss;
		logic        clr_done;
	} dp_stat_t;

	// parent state from its two children
	function automatic node_state_t merge_state(input node_state_t a, input node_state_t b);
		node_state_t r;
		if (a == NS_EMPTY && b == NS_EMPTY)
			r = NS_EMPTY;
		else if (a[1] && b[1])
			r = NS_FULL;
		else
			r = NS_PART;
		return r;
	endfunction

	// ceil(log2(count)) for 1 <= count <= PAGE_TOTAL
	function automatic logic [K_W-1:0] count_order(input logic [COUNT_W-1:0] count);
		logic [K_W-1:0] k;
		k = '0;
		for (int i = 0; i < PAGE_W; i++) begin
			if (count > (COUNT_W'(1) << i))
				k = K_W'(i + 1);
		end
		return k;
	endfunction

endpackage

// ===== rtl/tbpa_ram.sv =====
module tbpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tbpa_dp.sv =====
module tbpa_dp
	import tbpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                action,
	input  logic [COUNT_W-1:0]  page_count,
	input  logic [PAGE_W-1:0]   page_index,
	output logic                done,
	output logic [1:0]          status,
	output logic [PAGE_W-1:0]   block_page
);

	logic [NODE_W-1:0] node_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [LVL_W-1:0]  tgt_q;
	logic [K_W-1:0]    k_q;
	logic              action_q;
	logic [PAGE_W-1:0] page_q;
	logic              miss_q;
	node_state_t       cs_q;
	logic [PAGE_W-1:0] first_q;
	logic [NODE_W-1:0] clr_q;
	logic              done_q;
	result_status_t    status_q;
	logic [PAGE_W-1:0] block_q;

	logic              we;
	logic [NODE_W-1:0] waddr;
	logic [1:0]        wdata;
	logic [NODE_W-1:0] raddr;
	logic [1:0]        rdata;
	node_state_t       rd_st;
	node_state_t       merged;
	logic [NODE_W-1:0] node_shl;
	logic [PAGE_W-1:0] first_d;
	logic [K_W-1:0]    k_in;

	assign rd_st    = node_state_t'(rdata);
	assign merged   = merge_state(cs_q, rd_st);
	assign node_shl = node_q << k_q;
	assign first_d  = (cmd.wr_alloc || cmd.wr_empty)
		? (action_q ? page_q : node_shl[PAGE_W-1:0]) : first_q;
	assign k_in     = count_order(page_count);

	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = NS_EMPTY;
		if (cmd.clr) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (cmd.wr_alloc) begin
			we    = 1'b1;
			wdata = NS_ALLOC;
		end else if (cmd.wr_empty) begin
			we    = 1'b1;
		end else if (cmd.up) begin
			we    = 1'b1;
			waddr = node_q >> 1;
			wdata = merged;
		end
	end

	assign raddr = cmd.rd_sib ? (node_q ^ NODE_W'(1)) : node_q;

	tbpa_ram #(
		.WIDTH(2),
		.DEPTH(NODE_COUNT + 1)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			page_q   <= page_index;
			k_q      <= k_in;
			tgt_q    <= LVL_W'(TREE_LEVELS) - LVL_W'(k_in);
			miss_q   <= 1'b0;
			if (action) begin
				node_q <= {1'b1, page_index};
				lvl_q  <= LVL_W'(TREE_LEVELS);
			end else begin
				node_q <= NODE_W'(1);
				lvl_q  <= LVL_W'(1);
			end
		end else if (cmd.descend) begin
			node_q <= node_q << 1;
			lvl_q  <= lvl_q + LVL_W'(1);
		end else if (cmd.back) begin
			if (node_q[0]) begin
				node_q <= node_q >> 1;
				lvl_q  <= lvl_q - LVL_W'(1);
			end else begin
				node_q <= node_q + NODE_W'(1);
			end
		end else if (cmd.climb) begin
			miss_q <= miss_q | node_q[0];
			node_q <= node_q >> 1;
			lvl_q  <= lvl_q - LVL_W'(1);
		end else if (cmd.up) begin
			node_q <= node_q >> 1;
		end
		if (cmd.wr_alloc)
			cs_q <= NS_ALLOC;
		else if (cmd.wr_empty)
			cs_q <= NS_EMPTY;
		else if (cmd.up)
			cs_q <= merged;
		first_q <= first_d;
		status_q <= cmd.fin_status;
		block_q  <= (cmd.fin_status == RS_OK) ? first_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clr)
				clr_q <= clr_q + NODE_W'(1);
			done_q <= cmd.finish;
		end
	end

	assign stat.rd_state    = rd_st;
	assign stat.at_target   = (lvl_q == tgt_q);
	assign stat.is_root     = (node_q == NODE_W'(1));
	assign stat.is_odd      = node_q[0];
	assign stat.parent_root = ((node_q >> 1) == NODE_W'(1));
	assign stat.bad_count   = (page_count == '0) || (page_count > COUNT_W'(PAGE_TOTAL));
	assign stat.miss        = miss_q;
	assign stat.clr_done    = (clr_q == NODE_W'(NODE_COUNT));

	assign done       = done_q;
	assign status     = status_q;
	assign block_page = block_q;

endmodule

// ===== rtl/tbpa_ctrl.sv =====
module tbpa_ctrl
	import tbpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     action,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_A_RD  = 9'b000000100,
		S_A_EV  = 9'b000001000,
		S_A_BT  = 9'b000010000,
		S_U_RD  = 9'b000100000,
		S_U_EV  = 9'b001000000,
		S_F_RD  = 9'b010000000,
		S_F_EV  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.fin_status = RS_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (action)
						state_d = S_F_RD;
					else if (stat.bad_count) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = RS_BADCNT;
					end else
						state_d = S_A_RD;
				end
			end
			S_A_RD: begin
				cmd.rd_node = 1'b1;
				state_d     = S_A_EV;
			end
			S_A_EV: begin
				if (stat.rd_state[1] || (stat.at_target && stat.rd_state != NS_EMPTY))
					state_d = S_A_BT;
				else if (stat.at_target) begin
					cmd.wr_alloc = 1'b1;
					if (stat.is_root) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end else
						state_d = S_U_RD;
				end else begin
					cmd.descend = 1'b1;
					state_d     = S_A_RD;
				end
			end
			S_A_BT: begin
				if (stat.is_root) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = RS_NOSPACE;
					state_d        = S_IDLE;
				end else begin
					cmd.back = 1'b1;
					// left child steps over to its sibling, right child climbs on
					if (!stat.is_odd)
						state_d = S_A_RD;
				end
			end
			S_U_RD: begin
				cmd.rd_sib = 1'b1;
				state_d    = S_U_EV;
			end
			S_U_EV: begin
				cmd.up = 1'b1;
				if (stat.parent_root) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else
					state_d = S_U_RD;
			end
			S_F_RD: begin
				cmd.rd_node = 1'b1;
				state_d     = S_F_EV;
			end
			S_F_EV: begin
				if (stat.rd_state == NS_ALLOC) begin
					if (stat.miss) begin
						cmd.finish     = 1'b1;
						cmd.fin_status = RS_NOTHING;
						state_d        = S_IDLE;
					end else begin
						cmd.wr_empty = 1'b1;
						if (stat.is_root) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end else
							state_d = S_U_RD;
					end
				end else if (stat.is_root) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = RS_NOTHING;
					state_d        = S_IDLE;
				end else begin
					cmd.climb = 1'b1;
					state_d   = S_F_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/tree_buddy_page_allocator_unit.sv =====
// a bad count is rejected straight from idle; otherwise each node is read and then
// evaluated, each ancestor is repaired from its sibling, and the result is registered.
// allocate descends from the root to the target level, backtracking past full nodes.
// free climbs from the leaf to the allocated node; a rejected free repairs nothing. one request at a time,
// next start taken as the result shows. reset: asynchronous; a clearing pass
// over all NODE_COUNT+1 tree entries empties the tree with busy high; done cannot be stalled.
module tree_buddy_page_allocator_unit
	import tbpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [COUNT_W-1:0] page_count,
	input  logic [PAGE_W-1:0]  page_index,
	output logic               done,
	output logic [1:0]         status,
	output logic [PAGE_W-1:0]  block_page
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tbpa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	tbpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.action    (action),
		.page_count(page_count),
		.page_index(page_index),
		.done      (done),
		.status    (status),
		.block_page(block_page)
	);

endmodule

// ===== rtl/tbpa_checker.sv =====
module tbpa_checker
	import tbpa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [PAGE_W-1:0]  block_page
);

	// a failed request reports page zero
	a_fail_page: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != RS_OK |-> block_page == '0)
		else $error("nonzero block_page on failed request");

	// an accepted beat keeps the unit busy or answers at once
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted beat dropped");

	// a result only follows work
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without request");

	// the unit is free again while its result shows
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy during result");

endmodule

bind tree_buddy_page_allocator_unit tbpa_checker u_tbpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.block_page(block_page)
);

// ===== tb/tb.sv =====
module tb;
	import tbpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		result_status_t     status;
		logic [PAGE_W-1:0]  page;
	} outcome_t;

	class alloc_scoreboard;
		node_state_t tree[NODE_COUNT+1];
		outcome_t    outcome_q[$];
		int          live_starts[$];
		int          errors;
		int          checked;
		int          n_ok;
		int          n_nospace;
		int          n_badcnt;
		int          n_nothing;

		function void clear_tree();
			foreach (tree[i]) tree[i] = NS_EMPTY;
			live_starts.delete();
		endfunction

		function node_state_t node_at(int n);
			if (n < 1 || n > NODE_COUNT)
				return NS_FULL;
			return tree[n];
		endfunction

		function void repair(int n);
			node_state_t a, b;
			a = node_at(2 * n);
			b = node_at(2 * n + 1);
			if (a == NS_EMPTY && b == NS_EMPTY)
				tree[n] = NS_EMPTY;
			else if (a >= NS_FULL && b >= NS_FULL)
				tree[n] = NS_FULL;
			else
				tree[n] = NS_PART;
		endfunction

		// leftmost empty node at the target level, depth first
		function int claim_node(int n, int lvl, int target);
			int r;
			if (n < 1 || n > NODE_COUNT)
				return 0;
			if (tree[n] >= NS_FULL)
				return 0;
			if (lvl >= target) begin
				if (tree[n] != NS_EMPTY)
					return 0;
				tree[n] = NS_ALLOC;
				return n;
			end
			r = claim_node(2 * n, lvl + 1, target);
			if (r == 0)
				r = claim_node(2 * n + 1, lvl + 1, target);
			if (r != 0)
				repair(n);
			return r;
		endfunction

		function int first_page(int n);
			int lv;
			lv = $clog2(n + 1);
			return (n - (1 << (lv - 1))) << (TREE_LEVELS - lv);
		endfunction

		function void note_request(logic act, logic [COUNT_W-1:0] cnt, logic [PAGE_W-1:0] idx);
			outcome_t o;
			int k, n, pg;
			o.status = RS_OK;
			o.page   = '0;
			if (act == 1'b0) begin
				if (cnt == 0 || cnt > PAGE_TOTAL) begin
					o.status = RS_BADCNT;
				end else begin
					k = 0;
					while ((1 << k) < cnt) k++;
					n = claim_node(1, 1, TREE_LEVELS - k);
					if (n == 0) begin
						o.status = RS_NOSPACE;
					end else begin
						o.page = PAGE_W'(first_page(n));
						live_starts.push_back(first_page(n));
					end
				end
			end else begin
				n = PAGE_TOTAL + idx;
				while (n >= 1 && node_at(n) != NS_ALLOC) n = n >> 1;
				if (n == 0 || first_page(n) != idx) begin
					o.status = RS_NOTHING;
				end else begin
					pg = first_page(n);
					tree[n] = NS_EMPTY;
					n = n >> 1;
					while (n >= 1) begin
						repair(n);
						n = n >> 1;
					end
					o.page = PAGE_W'(pg);
					foreach (live_starts[i])
						if (live_starts[i] == pg) begin
							live_starts.delete(i);
							break;
						end
				end
			end
			case (o.status)
				RS_OK:      n_ok++;
				RS_NOSPACE: n_nospace++;
				RS_BADCNT:  n_badcnt++;
				default:    n_nothing++;
			endcase
			outcome_q.push_back(o);
		endfunction

		function void check_outcome(logic [1:0] st, logic [PAGE_W-1:0] pg);
			outcome_t o;
			checked++;
			if (outcome_q.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d page %0d", $time, st, pg);
				errors++;
				return;
			end
			o = outcome_q.pop_front();
			if (st !== o.status) begin
				$display("%0t: status mismatch: expected %0d actual %0d", $time, o.status, st);
				errors++;
			end
			if (pg !== o.page) begin
				$display("%0t: block_page mismatch: expected %0d actual %0d", $time, o.page, pg);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               action;
	logic [COUNT_W-1:0] page_count;
	logic [PAGE_W-1:0]  page_index;
	logic               done;
	logic [1:0]         status;
	logic [PAGE_W-1:0]  block_page;

	alloc_scoreboard sb;
	int stall_cycles;
	int burst_left;

	tree_buddy_page_allocator_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.page_count (page_count),
		.page_index (page_index),
		.done       (done),
		.status     (status),
		.block_page (block_page)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_outcome(status, block_page);
		if (done || (start && !busy))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("tree_buddy_page_allocator_unit regression: fail");
			$finish;
		end
	end

	// one request beat, with a random gap between bursts
	task automatic send_req(input logic act, input int cnt, input int idx);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 20);
		end
		burst_left--;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		action     <= act;
		page_count <= COUNT_W'(cnt);
		page_index <= PAGE_W'(idx);
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(act, COUNT_W'(cnt), PAGE_W'(idx));
	endtask

	task automatic alloc(input int cnt);
		send_req(1'b0, cnt, $urandom_range(0, PAGE_TOTAL - 1));
	endtask

	task automatic free_at(input int idx);
		send_req(1'b1, $urandom_range(0, (1 << COUNT_W) - 1), idx);
	endtask

	task automatic random_req();
		int sel, k, lo, j;
		sel = $urandom_range(0, 99);
		if (sel < 52) begin
			k = $urandom_range(0, 9);
			if ($urandom_range(0, 2) != 0)
				k = $urandom_range(0, 3);
			lo = (k == 0) ? 1 : (1 << (k - 1)) + 1;
			alloc($urandom_range(lo, 1 << k));
		end else if (sel < 90 && sb.live_starts.size() > 0) begin
			j = $urandom_range(0, sb.live_starts.size() - 1);
			free_at(sb.live_starts[j]);
		end else if (sel < 94 && sb.live_starts.size() > 0) begin
			// one to three pages past a live block's first page
			j = $urandom_range(0, sb.live_starts.size() - 1);
			free_at((sb.live_starts[j] + $urandom_range(1, 3)) % PAGE_TOTAL);
		end else if (sel < 97) begin
			free_at($urandom_range(0, PAGE_TOTAL - 1));
		end else begin
			alloc($urandom_range(0, (1 << COUNT_W) - 1));
		end
	endtask

	initial begin
		sb = new();
		sb.clear_tree();
		stall_cycles = 0;
		burst_left   = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = 1'b0;
		page_count = '0;
		page_index = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		alloc(0);
		alloc(PAGE_TOTAL + 1);
		alloc((1 << COUNT_W) - 1);
		alloc(PAGE_TOTAL);
		alloc(1);
		free_at(1);
		free_at(PAGE_TOTAL - 1);
		free_at(0);
		alloc(1);
		alloc(2);
		alloc(1);
		alloc(3);
		free_at(2);
		free_at(3);
		alloc(PAGE_TOTAL / 2);
		alloc(PAGE_TOTAL / 2 + 1);
		free_at(PAGE_TOTAL / 2);
		free_at(0);
		free_at(1);
		free_at(4);
		alloc(PAGE_TOTAL - 1);
		free_at(0);
		free_at(0);

		repeat (1800) random_req();
		start <= 1'b0;

		while (sb.outcome_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("checked %0d results: %0d ok, %0d no space, %0d bad count, %0d nothing there",
			sb.checked, sb.n_ok, sb.n_nospace, sb.n_badcnt, sb.n_nothing);
		$display("allocations of 1 to %0d pages, frees of live, unaligned and empty pages",
			PAGE_TOTAL);
		if (sb.errors == 0 && sb.outcome_q.size() == 0)
			$display("tree_buddy_page_allocator_unit regression: pass");
		else
			$display("tree_buddy_page_allocator_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tbpa_pkg.sv
rtl/tbpa_ram.sv
rtl/tbpa_dp.sv
rtl/tbpa_ctrl.sv
rtl/tree_buddy_page_allocator_unit.sv
rtl/tbpa_checker.sv
tb/tb.sv
